[sv/scwin_pkg.sv]
package scwin_pkg;

   localparam int unsigned DEF_MAX_K   = 128;
   localparam int unsigned DEF_MAX_SEQ = 1048576;
   localparam int unsigned CSR_W       = 8;
   localparam int unsigned SYM_W       = 10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_CALC,
      ST_DONE,
      ST_RESP
   } scwin_state_type;

   typedef struct packed {
      logic init;
      logic sample;
   } scwin_min_ctl_type;

endpackage

[sv/scwin_ram.sv]
module scwin_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/scwin_min_unit.sv]
module scwin_min_unit
   import scwin_pkg::*;
#(
   parameter int unsigned POS_W = 21
) (
   input  logic              clock,
   input  scwin_min_ctl_type ctl,
   input  logic [POS_W-1:0]  init_value,
   input  logic [POS_W-1:0]  sample_value,
   output logic [POS_W-1:0]  min_value
);

   logic [POS_W-1:0] min_ff;
   logic [POS_W-1:0] min_in;

   always_comb begin
      min_in = min_ff;
      if (ctl.init) begin
         min_in = init_value;
      end else if (ctl.sample && (sample_value < min_ff)) begin
         min_in = sample_value;
      end
   end

   always_ff @(posedge clock) begin
      min_ff <= min_in;
   end

   assign min_value = min_ff;

endmodule

[sv/shortest_covering_window_unit.sv]
// Channel  Direction  Ports
// req      in         req_valid, req_ready, req_symbol, req_last_item
// rsp      out        rsp_valid, rsp_ready, rsp_shortest_length, rsp_found, rsp_too_long
// csr      in         csr_valid, csr_ready, csr_required_count
//
// An item that does not complete coverage goes from ST_IDLE to ST_DONE; once all values 1..K
// have been seen, it also passes ST_SCAN, ST_DRAIN and ST_CALC, where the scan reads one stored
// last position per cycle from the single RAM read port into the shared min compare.
// Reset is synchronous and leaves no clearing pass: per-value seen flags mark which
// stored positions are valid. A final item's response is held until rsp_ready, and no
// new transaction is taken until then.
module shortest_covering_window_unit
   import scwin_pkg::*;
#(
   parameter int unsigned MAX_K   = DEF_MAX_K,
   parameter int unsigned MAX_SEQ = DEF_MAX_SEQ,
   parameter int unsigned POS_W   = $clog2(MAX_SEQ + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [SYM_W-1:0] req_symbol,
   input  logic             req_last_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [POS_W-1:0] rsp_shortest_length,
   output logic             rsp_found,
   output logic             rsp_too_long,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_required_count
);

   localparam int unsigned ADDR_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int unsigned K_W    = $clog2(MAX_K + 1);

   scwin_state_type   state_ff, state_in;
   logic [CSR_W-1:0]  kreg_ff, kreg_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [K_W-1:0]    cov_ff, cov_in;
   logic [POS_W-1:0]  best_ff, best_in;
   logic              ovf_ff, ovf_in;
   logic [MAX_K-1:0]  seen_ff, seen_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic              pend_ff, pend_in;
   logic              last_ff, last_in;
   logic [POS_W-1:0]  len_ff, len_in;
   logic              fnd_ff, fnd_in;
   logic              tl_ff, tl_in;

   logic [K_W-1:0]    k_eff;
   logic [K_W:0]      cov_sum;
   logic              in_range;
   logic [ADDR_W-1:0] sym_idx;
   logic              wr_en;
   logic [POS_W-1:0]  pos_next;
   logic [POS_W-1:0]  rd_data;
   logic [POS_W-1:0]  oldest;
   logic [POS_W-1:0]  win_len;
   scwin_min_ctl_type min_ctl;

   always_comb begin
      int unsigned k32;
      k32 = 32'(kreg_ff);
      if (k32 == 0) begin
         k32 = 1;
      end else if (k32 > MAX_K) begin
         k32 = MAX_K;
      end
      k_eff = K_W'(k32);
   end

   assign in_range = (32'(req_symbol) >= 32'd1) && (32'(req_symbol) <= 32'(k_eff));
   assign sym_idx  = ADDR_W'(req_symbol - SYM_W'(1));
   assign pos_next = pos_ff + POS_W'(1);
   assign win_len  = pos_ff - oldest + POS_W'(1);

   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_shortest_length = len_ff;
   assign rsp_found = fnd_ff;
   assign rsp_too_long = tl_ff;

   always_comb begin
      state_in   = state_ff;
      kreg_in    = kreg_ff;
      pos_in     = pos_ff;
      cov_in     = cov_ff;
      best_in    = best_ff;
      ovf_in     = ovf_ff;
      seen_in    = seen_ff;
      rd_addr_in = rd_addr_ff;
      pend_in    = 1'b0;
      last_in    = last_ff;
      len_in     = len_ff;
      fnd_in     = fnd_ff;
      tl_in      = tl_ff;
      wr_en      = 1'b0;
      min_ctl    = '0;
      cov_sum    = {1'b0, cov_ff};
      case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               kreg_in = csr_required_count;
               pos_in  = '0;
               cov_in  = '0;
               best_in = '1;
               ovf_in  = 1'b0;
               seen_in = '0;
            end else if (req_valid) begin
               last_in = req_last_item;
               if (32'(pos_ff) >= MAX_SEQ) begin
                  ovf_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  pos_in = pos_next;
                  if (in_range) begin
                     wr_en = 1'b1;
                     if (!seen_ff[sym_idx]) begin
                        seen_in[sym_idx] = 1'b1;
                        cov_sum = {1'b0, cov_ff} + (K_W + 1)'(1);
                     end
                  end
                  cov_in = K_W'(cov_sum);
                  if (cov_sum >= {1'b0, k_eff}) begin
                     min_ctl.init = 1'b1;
                     rd_addr_in   = '0;
                     state_in     = ST_SCAN;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_SCAN: begin
            pend_in        = 1'b1;
            min_ctl.sample = pend_ff;
            rd_addr_in     = rd_addr_ff + ADDR_W'(1);
            if (rd_addr_ff == ADDR_W'(k_eff - K_W'(1))) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            min_ctl.sample = pend_ff;
            state_in       = ST_CALC;
         end
         ST_CALC: begin
            if (win_len < best_ff) begin
               best_in = win_len;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (last_ff) begin
               if (ovf_ff) begin
                  len_in = '0;
                  fnd_in = 1'b0;
                  tl_in  = 1'b1;
               end else if (cov_ff >= k_eff) begin
                  len_in = best_ff;
                  fnd_in = 1'b1;
                  tl_in  = 1'b0;
               end else begin
                  len_in = '0;
                  fnd_in = 1'b0;
                  tl_in  = 1'b0;
               end
               state_in = ST_RESP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               pos_in   = '0;
               cov_in   = '0;
               best_in  = '1;
               ovf_in   = 1'b0;
               seen_in  = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kreg_ff <= CSR_W'(1);
         pos_ff  <= '0;
         cov_ff  <= '0;
         best_ff <= '1;
         ovf_ff  <= 1'b0;
         seen_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         kreg_ff <= kreg_in;
         pos_ff  <= pos_in;
         cov_ff  <= cov_in;
         best_ff <= best_in;
         ovf_ff  <= ovf_in;
         seen_ff <= seen_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      last_ff    <= last_in;
      len_ff     <= len_in;
      fnd_ff     <= fnd_in;
      tl_ff      <= tl_in;
   end

   scwin_ram #(
      .WIDTH (POS_W),
      .DEPTH (MAX_K)
   ) u_last_pos (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (sym_idx),
      .wr_data (pos_next),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   scwin_min_unit #(
      .POS_W (POS_W)
   ) u_min (
      .clock        (clock),
      .ctl          (min_ctl),
      .init_value   (pos_next),
      .sample_value (rd_data),
      .min_value    (oldest)
   );

   // A pending response blocks new input transactions.
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input accepted while a response is pending");

   // The scan only runs once every required value has been seen.
   a_scan_covered: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cov_ff >= k_eff))
      else $error("scan started without full coverage");

   // Overflow is only flagged once the position counter has reached MAX_SEQ.
   a_ovf_pos: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (32'(pos_ff) == MAX_SEQ))
      else $error("overflow flagged below the sequence limit");

   // A reported window is nonempty and no longer than the stream.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |->
         ((rsp_shortest_length != '0) && (rsp_shortest_length <= pos_ff)))
      else $error("reported window length out of bounds");

endmodule
